@@ rtl/blcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package blcc_pkg;

    localparam int unsigned BUTTON_W  = 5;
    localparam int unsigned LED_W     = 8;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned SPEED_W   = 4;
    localparam int unsigned TIME_W    = 16;
    localparam int unsigned CFG_W     = 8;
    localparam int unsigned STEP_W    = 3;
    localparam int unsigned S_DATA_W  = 8;
    localparam int unsigned M_DATA_W  = 16;

    localparam logic [CFG_W-1:0]   TICK_MS_RESET    = 8'd10;
    localparam logic [CFG_W-1:0]   DELAY_STEP_RESET = 8'd60;
    localparam logic [TIME_W-1:0]  DELAY_RESET      = 16'd900;
    localparam logic [TIME_W-1:0]  TIME_MAX         = 16'hFFFF;
    localparam logic [SPEED_W-1:0] SPEED_MAX        = 4'd15;
    localparam logic [STEP_W-1:0]  CHASE_LAST       = 3'd4;

    // configuration register indexes
    localparam logic CFG_TICK_MS    = 1'b0;
    localparam logic CFG_DELAY_STEP = 1'b1;

    // button positions
    localparam int unsigned BTN_LR   = 0;
    localparam int unsigned BTN_UP   = 1;
    localparam int unsigned BTN_DOWN = 2;
    localparam int unsigned BTN_RL   = 3;
    localparam int unsigned BTN_EXIT = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF_REL = 3'd0,
        MODE_OFF     = 3'd1,
        MODE_LR_REL  = 3'd2,
        MODE_LR      = 3'd3,
        MODE_RL_REL  = 3'd4,
        MODE_RL      = 3'd5,
        MODE_ADJ_REL = 3'd6,
        MODE_ADJ     = 3'd7
    } mode_t;

    // code 3 is unused and behaves as idle
    typedef enum logic [1:0] {
        PHASE_IDLE       = 2'd0,
        PHASE_WAIT_REL   = 2'd1,
        PHASE_WAIT_PRESS = 2'd2
    } phase_t;

endpackage

`default_nettype wire

@@ rtl/button_led_chaser_controller_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Item                         Handshake
// s_*       in         one tick: buttons_pressed    s_tvalid / s_tready
// m_*       out        led_pattern, mode, speed     m_tvalid / m_tready
// cfg_*     in         tick_ms, delay_step_ms       cfg_we, no wait
//
// One item per cycle sustained while m_tready does not stall the result. Ticks pass
// an input register, then the update logic (a 17-bit add and a 16-bit compare set
// the path) writes the state and the result register, which drives m_tvalid.
// Reset (rst_n, async, active low) gives mode off, speed 15, delay 900 ms.
// A stalled result register holds the item; the input register keeps taking
// a tick until it too is full.
module button_led_chaser_controller_unit
    import blcc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [4:0] buttons_pressed
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [7:0] led_pattern, [10:8] mode,
                                                // [14:11] speed
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_wdata
);

    // configuration
    logic [CFG_W-1:0]    tick_ms_reg;
    logic [CFG_W-1:0]    delay_step_reg;

    // input register
    logic                in_valid_reg;
    logic [BUTTON_W-1:0] btn_reg;

    // controller state
    mode_t               mode_reg,    mode_next;
    phase_t              phase_reg,   phase_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [STEP_W-1:0]   step_reg,    step_next;
    logic [LED_W-1:0]    led_reg,     led_next;
    logic [SPEED_W-1:0]  speed_reg,   speed_next;
    logic [TIME_W-1:0]   delay_reg,   delay_next;

    // result register
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic                advance;
    logic                none;
    logic [TIME_W:0]     elapsed_sum;
    logic [TIME_W-1:0]   elapsed_tick;
    logic [TIME_W:0]     delay_up;
    logic                chase_en;
    logic                chase_left;
    logic                adjust_en;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign none         = (btn_reg == '0);
    assign elapsed_sum  = {1'b0, elapsed_reg} + {{(TIME_W+1-CFG_W){1'b0}}, tick_ms_reg};
    assign elapsed_tick = elapsed_sum[TIME_W] ? TIME_MAX : elapsed_sum[TIME_W-1:0];
    assign delay_up     = {1'b0, delay_reg} + {{(TIME_W+1-CFG_W){1'b0}}, delay_step_reg};

    always_comb
    begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        elapsed_next = elapsed_tick;
        step_next    = step_reg;
        led_next     = led_reg;
        speed_next   = speed_reg;
        delay_next   = delay_reg;
        chase_en     = 1'b0;
        chase_left   = 1'b0;
        adjust_en    = 1'b0;

        // mode update
        case (mode_reg)
            MODE_OFF_REL:
            begin
                if (none)
                    mode_next = MODE_OFF;
                step_next  = '0;
                led_next   = '0;
                phase_next = PHASE_WAIT_REL;
            end
            MODE_OFF:
            begin
                if (btn_reg[BTN_LR])
                    mode_next = MODE_LR_REL;
                else if (btn_reg[BTN_UP] || btn_reg[BTN_DOWN])
                    mode_next = MODE_ADJ_REL;
                else if (btn_reg[BTN_RL])
                    mode_next = MODE_RL_REL;
            end
            MODE_LR_REL:  if (none) mode_next = MODE_LR;
            MODE_LR:      if (btn_reg[BTN_LR]) mode_next = MODE_OFF_REL;
            MODE_RL_REL:  if (none) mode_next = MODE_RL;
            MODE_RL:      if (btn_reg[BTN_RL]) mode_next = MODE_OFF_REL;
            MODE_ADJ_REL: if (none) mode_next = MODE_ADJ;
            default:
            begin
                if (btn_reg[BTN_LR] || btn_reg[BTN_EXIT])
                    mode_next = MODE_OFF_REL;
            end
        endcase

        // mode action on the updated mode
        case (mode_next)
            MODE_OFF_REL, MODE_OFF:
            begin
                if (btn_reg[BTN_LR])
                    mode_next = MODE_LR_REL;
            end
            MODE_LR_REL, MODE_LR:
            begin
                chase_en   = 1'b1;
                chase_left = 1'b1;
            end
            MODE_RL_REL, MODE_RL:
            begin
                chase_en = 1'b1;
            end
            default:
            begin
                adjust_en = 1'b1;
            end
        endcase

        if (chase_en && (elapsed_tick >= delay_reg))
        begin
            elapsed_next = '0;
            if (step_reg > CHASE_LAST)
            begin
                led_next  = '0;
                step_next = STEP_W'(1);
            end
            else
            begin
                led_next  = chase_left ? {led_reg[LED_W-2:0], 1'b1}
                                       : {1'b1, led_reg[LED_W-1:1]};
                step_next = step_reg + STEP_W'(1);
            end
        end

        if (adjust_en)
        begin
            case (phase_reg)
                PHASE_WAIT_REL:
                begin
                    if (none)
                        phase_next = PHASE_WAIT_PRESS;
                end
                PHASE_WAIT_PRESS:
                begin
                    if (btn_reg[BTN_UP])
                    begin
                        phase_next = PHASE_WAIT_REL;
                        if (speed_reg < SPEED_MAX)
                        begin
                            delay_next = delay_up[TIME_W] ? TIME_MAX : delay_up[TIME_W-1:0];
                            speed_next = speed_reg + SPEED_W'(1);
                            led_next   = LED_W'(speed_next);
                        end
                    end
                    else if (btn_reg[BTN_DOWN])
                    begin
                        phase_next = PHASE_WAIT_REL;
                        if (speed_reg != '0)
                        begin
                            delay_next = (delay_reg > TIME_W'(delay_step_reg))
                                       ? delay_reg - TIME_W'(delay_step_reg) : '0;
                            speed_next = speed_reg - SPEED_W'(1);
                            led_next   = LED_W'(speed_next);
                        end
                    end
                end
                default: ;  // idle: adjust not yet armed
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms_reg    <= TICK_MS_RESET;
            delay_step_reg <= DELAY_STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TICK_MS:    tick_ms_reg    <= cfg_wdata;
                CFG_DELAY_STEP: delay_step_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_OFF;
            phase_reg     <= PHASE_IDLE;
            elapsed_reg   <= '0;
            step_reg      <= '0;
            led_reg       <= '0;
            speed_reg     <= SPEED_MAX;
            delay_reg     <= DELAY_RESET;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                phase_reg     <= phase_next;
                elapsed_reg   <= elapsed_next;
                step_reg      <= step_next;
                led_reg       <= led_next;
                speed_reg     <= speed_next;
                delay_reg     <= delay_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            btn_reg <= s_tdata[BUTTON_W-1:0];
        if (advance)
            out_data_reg <= {1'b0, speed_next, mode_next, led_next};
    end

endmodule

`default_nettype wire
